// ===== src/salc_pkg.sv =====
// Shared types and constants for the set-associative LRU tag lookup.
`default_nettype none

package salc_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS = 2'd0,
        CFG_SET_BITS    = 2'd1,
        CFG_WAY_BITS    = 2'd2
    } t_cfg_idx;

    // access kind carried in tuser
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // stream widths
    localparam int IN_DATA_W = 32;
    localparam int CNT_W     = 32;
    localparam int OUT_W     = 168;

    // controller to datapath
    typedef struct packed {
        logic clr_step;  // zero one set row of the tag store
        logic load;      // take an input word, read its set row
        logic commit;    // write back the row, update counts, load output
    } t_salc_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;  // last row of the clearing pass
        logic out_free;  // output register can take a word this cycle
    } t_salc_status;

endpackage

`default_nettype wire

// ===== src/set_assoc_cache_lru_tag_lookup.sv =====
// Top level: set-associative tag lookup with age-based LRU replacement and hit counts.
// A result word is registered: the set row is read when its input word is accepted,
// then written back and the output word loaded in the write-back state. No new access
// is taken before that write-back. A stalled output holds the next access in its
// write-back state. Reset (i_rst_n low, synchronous) runs a clearing pass over all
// MAX_SETS rows, with s_axis_tready low until it ends. Config writes are always taken.
`default_nettype none

module set_assoc_cache_lru_tag_lookup #(
    parameter int MAX_SETS  = 256,
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 32,
    parameter int AGE_BITS  = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration writes
    input  wire logic                              i_cfg_we,
    input  wire logic [salc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [salc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // access words
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [salc_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,  // [31:0] address
    input  wire logic                              i_s_axis_tuser,  // [0] cmd
    // result words
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // [0] hit, [3:1] way_used, [4] filled_empty, [5] evicted, [37:6] total_accesses,
    // [69:38] total_hits, [101:70] read_accesses, [133:102] read_hits,
    // [165:134] write_hits, [167:166] zero
    output logic [salc_pkg::OUT_W-1:0]             o_m_axis_tdata
);
    import salc_pkg::*;

    t_salc_cmd    cmd;
    t_salc_status status;

    salc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    salc_dpath #(
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS),
        .AGE_BITS  (AGE_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_cmd    (i_s_axis_tuser),
        .i_in_addr   (i_s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata)
    );

    // a result is exactly one of hit, fill into an empty way, eviction
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> $onehot({o_m_axis_tdata[0], o_m_axis_tdata[4], o_m_axis_tdata[5]}))
        else $error("result is not exactly one of hit, fill, evict");

    // an accepted word blocks the input until its write-back
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while an access is in flight");

    // hit counts never pass the access counts they belong to
    a_hits_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[69:38] <= o_m_axis_tdata[37:6]) &&
                            (o_m_axis_tdata[133:102] <= o_m_axis_tdata[101:70]))
        else $error("hit count exceeds access count");

    // where the input ready falls right after reset, no result word may be valid
    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_s_axis_tready) |-> !$past(!i_rst_n) || !o_m_axis_tvalid)
        else $error("result word during clearing pass");

endmodule

`default_nettype wire

// ===== src/salc_ctrl.sv =====
// Controller: post-reset clearing pass, accept, and write-back sequencing.
`default_nettype none

module salc_ctrl (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    input  wire salc_pkg::t_salc_status  i_status,
    output logic                         o_in_ready,
    output salc_pkg::t_salc_cmd          o_cmd
);
    import salc_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && r_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_UPDATE;
                end
            end
            S_UPDATE: begin
                // hold the read row until the output register frees up
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // state and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_ready;

endmodule

`default_nettype wire

// ===== src/salc_dpath.sv =====
// Datapath: config registers, set row memory, hit/victim logic, counters, output word.
`default_nettype none

module salc_dpath #(
    parameter int MAX_SETS  = 256,
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 32,
    parameter int AGE_BITS  = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [salc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [salc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_in_cmd,
    input  wire logic [salc_pkg::IN_DATA_W-1:0]    i_in_addr,
    input  wire salc_pkg::t_salc_cmd               i_cmd,
    output salc_pkg::t_salc_status                 o_status,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic [salc_pkg::OUT_W-1:0]             o_out_data
);
    import salc_pkg::*;

    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int MSB     = $clog2(MAX_SETS + 1) - 1;  // floor(log2(MAX_SETS))
    localparam int SB_MAX  = (MSB < ADDR_BITS) ? MSB : ADDR_BITS;
    localparam int TAGS_LO = MAX_WAYS;
    localparam int AGES_LO = MAX_WAYS + MAX_WAYS * ADDR_BITS;
    localparam int ROW_W   = MAX_WAYS * (1 + ADDR_BITS + AGE_BITS);
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
    localparam logic [AGE_BITS-1:0] AGE_ONE = AGE_BITS'(1);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    // configuration registers
    logic [3:0] r_offset_bits;
    logic [3:0] r_set_bits;
    logic [1:0] r_way_bits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= 4'd4;
            r_set_bits    <= 4'd4;
            r_way_bits    <= 2'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data[3:0];
                CFG_SET_BITS:    r_set_bits    <= i_cfg_data[3:0];
                CFG_WAY_BITS:    r_way_bits    <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // address split of the incoming word
    logic [3:0]           sb;
    logic [4:0]           tshift;
    logic [ADDR_BITS-1:0] in_addr;
    logic [ADDR_BITS-1:0] above;
    logic [ADDR_BITS-1:0] set_mask;
    logic [SET_W-1:0]     n_set;
    logic [ADDR_BITS-1:0] n_tag;

    always_comb begin
        sb       = (r_set_bits > 4'(SB_MAX)) ? 4'(SB_MAX) : r_set_bits;
        tshift   = {1'b0, r_offset_bits} + {1'b0, sb};
        in_addr  = i_in_addr[ADDR_BITS-1:0];
        above    = in_addr >> r_offset_bits;
        set_mask = ~({ADDR_BITS{1'b1}} << sb);
        n_set    = SET_W'(above & set_mask);
        n_tag    = in_addr >> tshift;
    end

    // clearing pass address
    logic [SET_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= r_clr_addr + SET_W'(1);
        end
    end

    assign o_status.clr_last = (r_clr_addr == SET_W'(MAX_SETS - 1));

    // latched access
    logic                 r_is_write;
    logic [SET_W-1:0]     r_set;
    logic [ADDR_BITS-1:0] r_tag;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_write <= (i_in_cmd == CMD_WRITE);
            r_set      <= n_set;
            r_tag      <= n_tag;
        end
    end

    // set row memory: valid bits, tags, ages of all ways of one set
    logic [ROW_W-1:0] r_mem [MAX_SETS];
    logic [ROW_W-1:0] r_rd_row;
    logic [ROW_W-1:0] wr_row;
    logic [SET_W-1:0] wr_addr;
    logic             wr_en;

    assign wr_en   = i_cmd.clr_step | i_cmd.commit;
    assign wr_addr = i_cmd.clr_step ? r_clr_addr : r_set;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_cmd.clr_step ? '0 : wr_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd_row <= r_mem[n_set];
        end
    end

    // hit, fill and victim choice over the read row
    logic                 row_valid [MAX_WAYS];
    logic [ADDR_BITS-1:0] row_tag   [MAX_WAYS];
    logic [AGE_BITS-1:0]  row_age   [MAX_WAYS];
    logic [AGE_BITS-1:0]  aged      [MAX_WAYS];
    logic                 active    [MAX_WAYS];
    logic                 hit;
    logic                 found;
    logic [WAY_W-1:0]     hit_way;
    logic [WAY_W-1:0]     inv_way;
    logic [WAY_W-1:0]     best_way;
    logic [AGE_BITS-1:0]  best_age;
    logic [WAY_W-1:0]     used;

    always_comb begin
        hit      = 1'b0;
        found    = 1'b0;
        hit_way  = '0;
        inv_way  = '0;
        best_way = '0;
        best_age = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            row_valid[w] = r_rd_row[w];
            row_tag[w]   = r_rd_row[TAGS_LO + w*ADDR_BITS +: ADDR_BITS];
            row_age[w]   = r_rd_row[AGES_LO + w*AGE_BITS +: AGE_BITS];
            active[w]    = (w < (4'd1 << r_way_bits));
        end
        // first valid tag match
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (!hit && active[w] && row_valid[w] && row_tag[w] == r_tag) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
        // age every in-use way, saturating
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (active[w] && row_age[w] != AGE_MAX) begin
                aged[w] = row_age[w] + AGE_ONE;
            end else begin
                aged[w] = row_age[w];
            end
        end
        // lowest invalid way
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (!found && active[w] && !row_valid[w]) begin
                found   = 1'b1;
                inv_way = WAY_W'(w);
            end
        end
        // strictly oldest way, lowest on ties
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (active[w] && aged[w] > best_age) begin
                best_age = aged[w];
                best_way = WAY_W'(w);
            end
        end
        used = hit ? hit_way : (found ? inv_way : best_way);
    end

    // row to write back
    always_comb begin
        wr_row = r_rd_row;
        for (int w = 0; w < MAX_WAYS; w++) begin
            wr_row[AGES_LO + w*AGE_BITS +: AGE_BITS] = aged[w];
        end
        wr_row[used]                                  = 1'b1;
        wr_row[TAGS_LO + int'(used)*ADDR_BITS +: ADDR_BITS] = r_tag;
        wr_row[AGES_LO + int'(used)*AGE_BITS +: AGE_BITS]   = AGE_ONE;
    end

    // running counts
    logic [CNT_W-1:0] r_acc, r_hits, r_rd_acc, r_rd_hits, r_wr_hits;
    logic [CNT_W-1:0] n_acc, n_hits, n_rd_acc, n_rd_hits, n_wr_hits;

    always_comb begin
        n_acc     = sat_inc(r_acc);
        n_hits    = hit ? sat_inc(r_hits) : r_hits;
        n_rd_acc  = r_is_write ? r_rd_acc : sat_inc(r_rd_acc);
        n_rd_hits = (hit && !r_is_write) ? sat_inc(r_rd_hits) : r_rd_hits;
        n_wr_hits = (hit && r_is_write) ? sat_inc(r_wr_hits) : r_wr_hits;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_hits    <= '0;
            r_rd_acc  <= '0;
            r_rd_hits <= '0;
            r_wr_hits <= '0;
        end else if (i_cmd.commit) begin
            r_acc     <= n_acc;
            r_hits    <= n_hits;
            r_rd_acc  <= n_rd_acc;
            r_rd_hits <= n_rd_hits;
            r_wr_hits <= n_wr_hits;
        end
    end

    // output register
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= {2'b00, n_wr_hits, n_rd_hits, n_rd_acc, n_hits, n_acc,
                           (!hit && !found), (!hit && found), 3'(used), hit};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== tb/tb_set_assoc_cache_lru_tag_lookup.sv =====
// Self-checking testbench for the set-associative LRU tag lookup block.
`timescale 1ns / 1ps

module tb_set_assoc_cache_lru_tag_lookup;
    import salc_pkg::*;

    localparam int MAX_SETS       = 256;
    localparam int MAX_WAYS       = 8;
    localparam int ADDR_BITS      = 32;
    localparam int AGE_BITS       = 16;
    localparam int LINES          = MAX_SETS * MAX_WAYS;
    localparam int SET_BITS_MAX   = $clog2(MAX_SETS);
    localparam int PHASES         = 16;
    localparam int WORDS_PER_PHASE = 50;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    // one lookup result
    typedef struct {
        logic        hit;
        logic [2:0]  way;
        logic        filled;
        logic        evicted;
        logic [31:0] accesses;
        logic [31:0] hits;
        logic [31:0] reads;
        logic [31:0] read_hits;
        logic [31:0] write_hits;
    } t_lookup;

    // Tracks the tag store and counters, predicts each lookup, checks results
    class t_lookup_scoreboard;
        logic [3:0]          offset_bits;
        logic [3:0]          set_bits;
        logic [1:0]          way_bits;
        bit                  line_valid [LINES];
        logic [31:0]         line_tag [LINES];
        logic [AGE_BITS-1:0] line_age [LINES];
        logic [31:0]         n_access, n_hit, n_read, n_read_hit, n_write_hit;
        t_lookup             expected_lookups [$];
        int                  errors;
        int                  checked;

        function new();
            offset_bits = 4'd4;
            set_bits    = 4'd4;
            way_bits    = 2'd1;
            for (int i = 0; i < LINES; i++) begin
                line_valid[i] = 1'b0;
                line_tag[i]   = '0;
                line_age[i]   = '0;
            end
            n_access    = '0;
            n_hit       = '0;
            n_read      = '0;
            n_read_hit  = '0;
            n_write_hit = '0;
            errors      = 0;
            checked     = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [3:0] val);
            case (idx)
                CFG_OFFSET_BITS: offset_bits = val;
                CFG_SET_BITS:    set_bits    = val;
                CFG_WAY_BITS:    way_bits    = val[1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_lookups.size();
        endfunction

        // predict the lookup for an accepted access word
        function void note_access(logic cmd, logic [31:0] addr);
            int unsigned sb, ways, off, tshift, base, idx, best, best_age;
            logic [31:0] set_idx, tag;
            bit          found;
            t_lookup     r;
            off  = offset_bits;
            sb   = (set_bits > SET_BITS_MAX) ? SET_BITS_MAX : set_bits;
            ways = 1 << way_bits;
            if (ways > MAX_WAYS) ways = MAX_WAYS;
            set_idx = (off < 32) ? (addr >> off) : 32'd0;
            set_idx = set_idx & ((32'd1 << sb) - 32'd1);
            tshift  = off + sb;
            tag     = (tshift < ADDR_BITS) ? (addr >> tshift) : 32'd0;
            base    = (set_idx % MAX_SETS) * MAX_WAYS;
            r.hit     = 1'b0;
            r.way     = '0;
            r.filled  = 1'b0;
            r.evicted = 1'b0;

            // tag compare; the first match takes age 1, everything else ages
            for (int w = 0; w < ways; w++) begin
                idx = base + w;
                if (!r.hit && line_valid[idx] && line_tag[idx] == tag) begin
                    r.hit = 1'b1;
                    r.way = w[2:0];
                    line_age[idx] = AGE_BITS'(1);
                end else if (line_age[idx] != AGE_MAX) begin
                    line_age[idx] = line_age[idx] + 1'b1;
                end
            end

            // miss: lowest invalid way, else strictly oldest (lowest on ties)
            if (!r.hit) begin
                found = 1'b0;
                best  = 0;
                for (int w = 0; w < ways; w++) begin
                    if (!found && !line_valid[base + w]) begin
                        best  = w;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    r.filled = 1'b1;
                end else begin
                    best_age = 0;
                    for (int w = 0; w < ways; w++) begin
                        if (line_age[base + w] > best_age) begin
                            best_age = line_age[base + w];
                            best     = w;
                        end
                    end
                    r.evicted = 1'b1;
                end
                r.way = best[2:0];
                line_valid[base + best] = 1'b1;
                line_tag[base + best]   = tag;
                line_age[base + best]   = AGE_BITS'(1);
            end

            // saturating counts
            if (n_access != '1) n_access++;
            if (cmd == CMD_READ && n_read != '1) n_read++;
            if (r.hit) begin
                if (n_hit != '1) n_hit++;
                if (cmd == CMD_WRITE) begin
                    if (n_write_hit != '1) n_write_hit++;
                end else if (n_read_hit != '1) begin
                    n_read_hit++;
                end
            end
            r.accesses   = n_access;
            r.hits       = n_hit;
            r.reads      = n_read;
            r.read_hits  = n_read_hit;
            r.write_hits = n_write_hit;
            expected_lookups = {expected_lookups, r};
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // compare one result word against the oldest prediction
        function void check_word(logic [OUT_W-1:0] d);
            t_lookup e;
            if (expected_lookups.size() == 0) begin
                $error("result word 0x%0h with no lookup outstanding", d);
                errors++;
                return;
            end
            e = expected_lookups.pop_front();
            checked++;
            compare_field("hit",            e.hit,        d[0]);
            compare_field("way_used",       e.way,        d[3:1]);
            compare_field("filled_empty",   e.filled,     d[4]);
            compare_field("evicted",        e.evicted,    d[5]);
            compare_field("total_accesses", e.accesses,   d[37:6]);
            compare_field("total_hits",     e.hits,       d[69:38]);
            compare_field("read_accesses",  e.reads,      d[101:70]);
            compare_field("read_hits",      e.read_hits,  d[133:102]);
            compare_field("write_hits",     e.write_hits, d[165:134]);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;   // [31:0] address
    logic                  i_s_axis_tuser;   // [0] cmd
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // [0] hit, [3:1] way_used, [4] filled_empty, [5] evicted, [37:6] total_accesses,
    // [69:38] total_hits, [101:70] read_accesses, [133:102] read_hits, [165:134] write_hits
    logic [OUT_W-1:0]      o_m_axis_tdata;

    t_lookup_scoreboard board = new();
    int idle_cycles = 0;

    set_assoc_cache_lru_tag_lookup #(
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS),
        .AGE_BITS  (AGE_BITS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // monitor and watchdog, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && i_s_axis_tvalid && o_s_axis_tready === 1'b1) begin
            board.note_access(i_s_axis_tuser, i_s_axis_tdata);
            idle_cycles = 0;
        end else if (i_rst_n === 1'b1 && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (i_rst_n === 1'b1 && o_m_axis_tvalid === 1'b1 && i_m_axis_tready)
            board.check_word(o_m_axis_tdata);
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random stalls, quiet runs, and one long hold-off to back up the input
    initial begin
        int  stall_left;
        int  run_left;
        int  hold_left;
        bit  hold_done;
        stall_left = 0;
        run_left   = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && board.checked >= 150) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (run_left > 0)
                    run_left--;
                else if ($urandom_range(0, 29) == 0)
                    run_left = $urandom_range(20, 60);
                else if ($urandom_range(0, 2) == 0)
                    stall_left = gap_len();
            end
        end
    end

    // offer one access word and hold it until taken, then, for a nonzero gap, drop valid and wait out the gap
    task automatic send_access(input logic cmd, input logic [31:0] addr, input int gap);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= addr;
        i_s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (o_s_axis_tready !== 1'b1) @(posedge i_clk);
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= $urandom;
            i_s_axis_tuser  <= 1'($urandom_range(0, 1));
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // stop offering and wait for every predicted result
    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [3:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        board.set_reg(idx, val);
    endtask

    task automatic configure(input logic [3:0] off, input logic [3:0] sets,
                             input logic [3:0] ways);
        write_reg(CFG_OFFSET_BITS, off);
        write_reg(CFG_SET_BITS, sets);
        write_reg(CFG_WAY_BITS, ways);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // stimulus
    initial begin
        logic [32:0] directed [14];
        int          fixed_off [8];
        int          fixed_set [8];
        int          fixed_way [8];
        logic [3:0]  off, sets, ways;
        int          sb, tshift, nway, gap;
        bit          no_gaps;
        logic [31:0] tag_pool [$];
        logic [31:0] set_pool [$];
        logic [31:0] addr, tag_v, set_v;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_OFFSET_BITS;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = CMD_READ;

        // {cmd, address} at the reset setting: 16-byte lines, 16 sets, 2 ways
        directed = '{
            {CMD_READ,  32'h0000_0000},  // fill way 0
            {CMD_READ,  32'h0000_000F},  // read hit
            {CMD_WRITE, 32'h0000_0100},  // fill way 1
            {CMD_WRITE, 32'h0000_010F},  // write hit
            {CMD_READ,  32'h0000_0200},  // evict oldest
            {CMD_WRITE, 32'h0000_0000},  // evict again
            {CMD_READ,  32'hFFFF_FFFF},  // top set, top tag
            {CMD_WRITE, 32'hFFFF_FFF0},  // hit
            {CMD_READ,  32'h0000_00F0},  // fill second way of top set
            {CMD_WRITE, 32'hFFFF_FF0F},  // set 0, evict
            {CMD_READ,  32'hAAAA_AAAA},
            {CMD_WRITE, 32'h5555_5555},
            {CMD_READ,  32'h1234_5678},
            {CMD_READ,  32'h1234_5678}
        };
        // corner settings: oversized set and offset fields, one way and all ways
        fixed_off = '{0, 15, 12, 13, 0, 4, 1, 8};
        fixed_set = '{0, 15, 8, 9, 8, 2, 15, 3};
        fixed_way = '{0, 3, 3, 2, 0, 3, 2, 1};

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i])
            send_access(directed[i][32], directed[i][31:0], gap_len());
        drain();

        for (int p = 0; p < PHASES; p++) begin
            if (p < 8) begin
                off  = 4'(fixed_off[p]);
                sets = 4'(fixed_set[p]);
                ways = 4'(fixed_way[p]);
            end else begin
                off  = 4'($urandom_range(0, 15));
                sets = 4'($urandom_range(0, 15));
                ways = 4'($urandom_range(0, 15));
            end
            configure(off, sets, ways);

            // small pools of sets and tags so lines hit and get evicted
            sb     = (sets > SET_BITS_MAX) ? SET_BITS_MAX : sets;
            tshift = off + sb;
            nway   = 1 << ways[1:0];
            tag_pool.delete();
            set_pool.delete();
            repeat ($urandom_range(1, 4))
                set_pool = {set_pool, $urandom & ((32'd1 << sb) - 32'd1)};
            repeat (nway + $urandom_range(0, 2))
                tag_pool = {tag_pool, $urandom >> tshift};
            no_gaps = ($urandom_range(0, 3) == 0);

            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if ($urandom_range(0, 99) < 85) begin
                    tag_v = tag_pool[$urandom_range(0, tag_pool.size() - 1)];
                    set_v = set_pool[$urandom_range(0, set_pool.size() - 1)];
                    addr  = (tag_v << tshift) | (set_v << off)
                          | ($urandom & ((32'd1 << off) - 32'd1));
                end else begin
                    addr = $urandom;
                end
                gap = no_gaps ? 0 : gap_len();
                send_access(1'($urandom_range(0, 1)), addr, gap);
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (board.pending() != 0) begin
            $error("%0d lookups never produced a result", board.pending());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
